>>> hdl/kpcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpcc_pkg
// shared types, sizes and register indexes of the key period coincidence
// counter
// ----------------------------------------------------------------------------
package kpcc_pkg;

	localparam int MAX_SHIFT  = 29;
	localparam int COUNT_BITS = 32;
	localparam int OUT_BITS   = 32;
	localparam int CFG_W      = 5;
	localparam int LETTER_W   = 5;
	localparam int SHIFT_W    = $clog2(MAX_SHIFT + 1);
	localparam int CMP_W      = (SHIFT_W > CFG_W) ? SHIFT_W : CFG_W;
	localparam int LEVELS     = (MAX_SHIFT > 1) ? $clog2(MAX_SHIFT) : 1;

	localparam logic [CFG_W-1:0] RESET_MIN_SHIFT = CFG_W'(6);
	localparam logic [CFG_W-1:0] RESET_MAX_SHIFT = CFG_W'(29);

	// configuration register indexes
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_SHIFT = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_SHIFT = 1'b1;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [SHIFT_W-1:0]    shift_t;

	// one tap of the delay line as it moves from cell to cell
	typedef struct packed {
		logic                valid;
		logic [LETTER_W-1:0] letter;
	} link_t;

	// control broadcast to every cell
	typedef struct packed {
		logic                take;
		logic                clear;
		logic [LETTER_W-1:0] letter;
		logic [CFG_W-1:0]    min_shift;
		logic [CFG_W-1:0]    max_shift;
	} cell_ctl_t;

	// candidate in the best-shift search
	typedef struct packed {
		shift_t shift;
		count_t count;
	} cand_t;

	function automatic count_t sat_inc(input count_t v);
		sat_inc = (v == '1) ? v : v + count_t'(1);
	endfunction

	// number of nodes at a level of the search tree
	function automatic int lvl_n(input int l);
		lvl_n = ((MAX_SHIFT - 1) >> l) + 1;
	endfunction

	function automatic logic [OUT_BITS-1:0] clamp_out(input count_t v);
		logic [63:0] wide;
		wide = 64'(v);
		clamp_out = (wide > 64'hFFFF_FFFF) ? '1 : OUT_BITS'(wide);
	endfunction

endpackage
`default_nettype wire

>>> hdl/kpcc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpcc_cell
// one shift of the row: a delay tap, its compare and its saturating count
// ----------------------------------------------------------------------------
module kpcc_cell
	import kpcc_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  shift_t      shift,
	input  cell_ctl_t   ctl,
	input  link_t       link_in,
	output link_t       link_out,
	output cand_t       snap
);

	logic                letter_q;
	logic [LETTER_W-1:0] tap_q;
	logic                valid_q;
	count_t              count_q;
	cand_t               snap_q;
	logic                in_range;
	logic                hit;
	count_t              count_nxt;

	assign in_range = (CMP_W'(shift) >= CMP_W'(ctl.min_shift)) &&
	                  (CMP_W'(shift) <= CMP_W'(ctl.max_shift));
	assign hit       = ctl.take && in_range && valid_q && (tap_q == ctl.letter);
	assign count_nxt = hit ? sat_inc(count_q) : count_q;

	// letter_q only mirrors the tap valid for the neighbor
	assign letter_q = valid_q;
	assign link_out = '{valid: letter_q, letter: tap_q};
	assign snap     = snap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			count_q <= '0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (ctl.take)
				valid_q <= link_in.valid;
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take)
			tap_q <= link_in.letter;
		if (ctl.clear) begin
			snap_q.count <= count_nxt;
			snap_q.shift <= (count_nxt == '0) ? '0 : shift;
		end
	end

endmodule
`default_nettype wire

>>> hdl/kpcc_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpcc_merge
// registered node of the best-shift tree, left side wins ties
// ----------------------------------------------------------------------------
module kpcc_merge
	import kpcc_pkg::*;
(
	input  wire   clk,
	input  wire   en,
	input  cand_t left,
	input  cand_t right,
	output cand_t win
);

	cand_t win_q;

	always_ff @(posedge clk) begin
		if (en)
			win_q <= (right.count > left.count) ? right : left;
	end

	assign win = win_q;

endmodule
`default_nettype wire

>>> hdl/key_period_coincidence_counter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key_period_coincidence_counter_unit
// counts letter coincidences at every candidate key period of a text
// ----------------------------------------------------------------------------
// usage
// - s_* takes one ciphertext byte per transfer, s_tlast marks the end of a
//   text; bytes 0xE0..0xFF are letters, all others are skipped
// - a row of cells, one per shift, holds the delay line and the counts;
//   shifts are compared in parallel: one byte per cycle while s_tready is high
// - the last byte snapshots all counts and clears the row, so the next text
//   can start in the following cycle
// - the snapshot runs through a registered pairwise tree of log2(MAX_SHIFT)
//   levels (5 here); the result appears on m_* once it has passed every tree
//   level, one result per text
// - when m_tready is low the tree holds and empty stages fill up; s_tready
//   drops only once every tree stage holds a pending result
// - cfg_* writes min_shift (index 0) or max_shift (index 1); always ready
// - after arst_n the row is empty, counts are zero, min_shift is 6 and
//   max_shift is 29; no clearing pass is needed
// ----------------------------------------------------------------------------
module key_period_coincidence_counter_unit
	import kpcc_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	// input stream
	input  wire                    s_tvalid,
	output logic                   s_tready,
	input  wire  [7:0]             s_tdata,    // [7:0] text_byte
	input  wire                    s_tlast,    // is_last
	// result stream
	output logic                   m_tvalid,
	input  wire                    m_tready,
	output logic [71:0]            m_tdata,    // [4:0] best_shift, [36:5] best_count,
	                                           // [68:37] letter_total, [71:69] zero
	// configuration writes
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire  [CFG_INDEX_W-1:0] cfg_index,
	input  wire  [CFG_W-1:0]       cfg_data
);

	logic [CFG_W-1:0] min_shift_q;
	logic [CFG_W-1:0] max_shift_q;
	count_t           seen_q;
	count_t           seen_nxt;
	logic             acc;
	logic             is_letter;
	cell_ctl_t        ctl;
	link_t            head;
	link_t            chain [MAX_SHIFT];

	// search tree state, level 0 is the snapshot inside the cells
	cand_t            lvl   [LEVELS+1][MAX_SHIFT];
	logic             vld_q [LEVELS+1];
	count_t           tot_q [LEVELS+1];
	logic             free  [LEVELS+2];

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_shift_q <= RESET_MIN_SHIFT;
			max_shift_q <= RESET_MAX_SHIFT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MIN_SHIFT: min_shift_q <= cfg_data;
				REG_MAX_SHIFT: max_shift_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input transfer and letter decode
	assign acc       = s_tvalid && s_tready;
	assign is_letter = (s_tdata[7:5] == 3'b111);
	assign s_tready  = free[0];

	assign ctl = '{take:      acc && is_letter,
	               clear:     acc && s_tlast,
	               letter:    s_tdata[LETTER_W-1:0],
	               min_shift: min_shift_q,
	               max_shift: max_shift_q};

	// the newest letter enters the first cell
	assign head = '{valid: 1'b1, letter: s_tdata[LETTER_W-1:0]};

	// letter total, saturating
	assign seen_nxt = ctl.take ? sat_inc(seen_q) : seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seen_q <= '0;
		else if (ctl.clear)
			seen_q <= '0;
		else
			seen_q <= seen_nxt;
	end

	// row of cells, cell i counts shift i+1
	for (genvar i = 0; i < MAX_SHIFT; i++) begin : g_cell
		kpcc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (SHIFT_W'(i + 1)),
			.ctl      (ctl),
			.link_in  ((i == 0) ? head : chain[(i == 0) ? 0 : i - 1]),
			.link_out (chain[i]),
			.snap     (lvl[0][i])
		);
	end

	// stage flow: a stage loads when empty or when its content moves on
	assign free[LEVELS+1] = m_tready;
	for (genvar l = 0; l <= LEVELS; l++) begin : g_free
		assign free[l] = !vld_q[l] || free[l+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l <= LEVELS; l++)
				vld_q[l] <= 1'b0;
		end else begin
			if (free[0])
				vld_q[0] <= ctl.clear;
			for (int l = 1; l <= LEVELS; l++)
				if (free[l])
					vld_q[l] <= vld_q[l-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear)
			tot_q[0] <= seen_nxt;
		for (int l = 1; l <= LEVELS; l++)
			if (free[l])
				tot_q[l] <= tot_q[l-1];
	end

	// pairwise search, odd leftovers meet an empty candidate
	for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
		for (genvar j = 0; j < lvl_n(l); j++) begin : g_node
			cand_t rgt;
			if (2 * j + 1 < lvl_n(l - 1)) begin : g_pair
				assign rgt = lvl[l-1][2*j+1];
			end else begin : g_pad
				assign rgt = '0;
			end
			kpcc_merge u_merge (
				.clk   (clk),
				.en    (free[l]),
				.left  (lvl[l-1][2*j]),
				.right (rgt),
				.win   (lvl[l][j])
			);
		end
	end

	// result
	assign m_tvalid = vld_q[LEVELS];
	assign m_tdata  = {3'b000,
	                   clamp_out(tot_q[LEVELS]),
	                   clamp_out(lvl[LEVELS][0].count),
	                   5'(lvl[LEVELS][0].shift)};

endmodule
`default_nettype wire
